### rtl/core/assert_macros.svh
// Assertion macros shared by the date adder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define GDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define GDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gda_pkg.sv
// Shared widths, constants, interface structs and month length for the date adder.
package gda_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned WDAY_W      = 3;
  localparam int unsigned CENT_W      = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SUM_W       = OFFSET_BITS + 1;
  localparam int unsigned UNIT_W      = (SUM_W > YEAR_W + 1) ? SUM_W : YEAR_W + 1;

  localparam int unsigned CENTURY = 100;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAYS_LONG  = DAY_W'(31);
  localparam logic [DAY_W-1:0] DAYS_SHORT = DAY_W'(30);
  localparam logic [DAY_W-1:0] DAYS_FEB_L = DAY_W'(29);
  localparam logic [DAY_W-1:0] DAYS_FEB   = DAY_W'(28);

  typedef struct packed {
    logic start;
    logic take;
  } gda_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gda_stat_t;

  typedef struct packed {
    logic               err;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [CENT_W-1:0]  cent;
    logic [CENT_W-1:0]  yrem;
  } gda_res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (month == MONTH_FEB) begin
      len = leap ? DAYS_FEB_L : DAYS_FEB;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      len = DAYS_SHORT;
    end else begin
      len = DAYS_LONG;
    end
    return len;
  endfunction

endpackage

### rtl/core/gda_walk.sv
// Iterative century split and month-by-month date walk on one shared adder.
`include "assert_macros.svh"

module gda_walk (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  gda_pkg::gda_ctrl_t                       ctrl_i,
  input  logic signed [gda_pkg::OFFSET_BITS-1:0]   offset_i,
  input  logic        [gda_pkg::YEAR_W-1:0]        year_i,
  input  logic        [gda_pkg::MONTH_W-1:0]       month_i,
  input  logic        [gda_pkg::DAY_W-1:0]         day_i,
  output gda_pkg::gda_stat_t                       stat_o,
  output gda_pkg::gda_res_t                        res_o
);
  import gda_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  localparam int unsigned      CNT_W     = $clog2(CENT_W);
  localparam logic [CNT_W-1:0] CNT_TOP   = CNT_W'(CENT_W - 1);
  localparam logic [UNIT_W-1:0] CENT_U   = UNIT_W'(CENTURY);
  localparam logic [CENT_W-1:0] YREM_TOP = CENT_W'(CENTURY - 1);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [YEAR_W-1:0]  rem_q, rem_d;
  logic [UNIT_W-1:0]  sum_q, sum_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [MONTH_W-1:0] mon_q, mon_d;
  logic [CENT_W-1:0]  cent_q, cent_d;
  logic [CENT_W-1:0]  yrem_q, yrem_d;
  logic [CENT_W-1:0]  cent0_q, cent0_d;
  logic [CENT_W-1:0]  yrem0_q, yrem0_d;
  logic               err_q, err_d;

  logic               leap;
  logic [DAY_W-1:0]   ml_cur;
  logic [DAY_W-1:0]   ml_prev;
  logic               go_back;
  logic [UNIT_W-1:0]  unit_a;
  logic [UNIT_W-1:0]  unit_b;
  logic [UNIT_W-1:0]  unit_y;
  logic               unit_neg;
  logic               unit_pos;
  logic [YEAR_W-1:0]  rem_nx;
  logic [CENT_W-1:0]  cent_nx;

  assign leap    = (yrem_q == '0) ? (cent_q[1:0] == 2'b00) : (yrem_q[1:0] == 2'b00);
  assign ml_cur  = month_len(mon_q, leap);
  // January steps back into December of the prior year, always 31 days
  assign ml_prev = (mon_q == MONTH_JAN) ? DAYS_LONG : month_len(mon_q - 1'b1, leap);
  assign go_back = sum_q[UNIT_W-1] || (sum_q == '0);

  // Shared adder: trial subtract during the century split, month add or subtract in the walk
  always_comb begin
    if (state_q == ST_DIV) begin
      unit_a = UNIT_W'(rem_q);
      unit_b = '0 - (CENT_U << cnt_q);
    end else if (go_back) begin
      unit_a = sum_q;
      unit_b = UNIT_W'(ml_prev);
    end else begin
      unit_a = sum_q;
      unit_b = '0 - UNIT_W'(ml_cur);
    end
  end

  assign unit_y   = unit_a + unit_b;
  assign unit_neg = unit_y[UNIT_W-1];
  assign unit_pos = !unit_neg && (unit_y != '0);
  assign rem_nx   = unit_neg ? rem_q : unit_y[YEAR_W-1:0];
  assign cent_nx  = {cent_q[CENT_W-2:0], !unit_neg};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    year_d  = year_q;
    mon_d   = mon_q;
    cent_d  = cent_q;
    yrem_d  = yrem_q;
    cent0_d = cent0_q;
    yrem0_d = yrem0_q;
    err_d   = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.start) begin
          rem_d   = year_i;
          year_d  = year_i;
          mon_d   = month_i;
          sum_d   = UNIT_W'(offset_i) + UNIT_W'(day_i);
          cnt_d   = CNT_TOP;
          cent_d  = '0;
          err_d   = 1'b0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = rem_nx;
        cent_d = cent_nx;
        if (cnt_q == '0) begin
          yrem_d  = rem_nx[CENT_W-1:0];
          cent0_d = cent_nx;
          yrem0_d = rem_nx[CENT_W-1:0];
          state_d = ST_WALK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_WALK: begin
        if (go_back) begin
          if (mon_q == MONTH_JAN) begin
            if (year_q == YEAR_MIN) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              sum_d  = unit_y;
              mon_d  = MONTH_DEC;
              year_d = year_q - 1'b1;
              if (yrem_q == '0) begin
                yrem_d = YREM_TOP;
                cent_d = cent_q - 1'b1;
              end else begin
                yrem_d = yrem_q - 1'b1;
              end
            end
          end else begin
            sum_d = unit_y;
            mon_d = mon_q - 1'b1;
          end
        end else if (unit_pos) begin
          if (mon_q == MONTH_DEC) begin
            if (year_q == YEAR_MAX) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              sum_d  = unit_y;
              mon_d  = MONTH_JAN;
              year_d = year_q + 1'b1;
              if (yrem_q == YREM_TOP) begin
                yrem_d = '0;
                cent_d = cent_q + 1'b1;
              end else begin
                yrem_d = yrem_q + 1'b1;
              end
            end
          end else begin
            sum_d = unit_y;
            mon_d = mon_q + 1'b1;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctrl_i.take) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    sum_q   <= sum_d;
    year_q  <= year_d;
    mon_q   <= mon_d;
    cent_q  <= cent_d;
    yrem_q  <= yrem_d;
    cent0_q <= cent0_d;
    yrem0_q <= yrem0_d;
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);

  assign res_o.err   = err_q;
  assign res_o.year  = year_q;
  assign res_o.month = mon_q;
  assign res_o.day   = sum_q[DAY_W-1:0];
  // On a range error report the century split of the held year
  assign res_o.cent  = err_q ? cent0_q : cent_q;
  assign res_o.yrem  = err_q ? yrem0_q : yrem_q;

  `GDA_ASSERT_IMPL(a_start_idle, ctrl_i.start, state_q == ST_IDLE, "request started while busy")
  `GDA_ASSERT_IMPL(a_walk_month, state_q == ST_WALK, mon_q >= MONTH_JAN && mon_q <= MONTH_DEC, "month out of range in walk")
  `GDA_ASSERT_IMPL(a_year_split, state_q == ST_WALK || state_q == ST_DONE, yrem_q <= YREM_TOP && (YEAR_W'(cent_q) * YEAR_W'(CENTURY) + YEAR_W'(yrem_q)) == year_q, "century split out of step with year")
  `GDA_ASSERT_IMPL(a_done_day, state_q == ST_DONE && !err_q, sum_q != '0 && sum_q <= UNIT_W'(ml_cur), "day not normalized at finish")

endmodule

### rtl/core/gregorian_date_add_days.sv
// Gregorian date adder top level: configuration, current date, handshakes and weekday.
//
// Holds a current Gregorian date, loaded by writes to start_year (index 0),
// start_month (index 1) and start_day (index 2); out-of-range years and months
// saturate, a day is kept as written and normalized by the next request. Each
// request adds a signed day offset and returns the new date, its weekday
// (0 is Sunday) and range_error, which is set when the year would leave
// 1..9999; the date is then held and reported unchanged. For each request
// the walk unit first splits the year into century and remainder, then its
// single adder advances or retreats one month per cycle. An offset of 32767
// days crosses about 1080 months. The result sits in an output register,
// and the next request is taken once the walk unit is idle again.
`include "assert_macros.svh"

module gregorian_date_add_days (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic        [gda_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic        [gda_pkg::YEAR_W-1:0]       cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [gda_pkg::OFFSET_BITS-1:0]  day_offset_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic        [gda_pkg::YEAR_W-1:0]       out_year_o,
  output logic        [gda_pkg::MONTH_W-1:0]      out_month_o,
  output logic        [gda_pkg::DAY_W-1:0]        out_day_o,
  output logic        [gda_pkg::WDAY_W-1:0]       weekday_o,
  output logic                                    range_error_o
);
  import gda_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_YEAR  = 2'd0,
    CFG_START_MONTH = 2'd1,
    CFG_START_DAY   = 2'd2
  } cfg_idx_e;

  localparam int unsigned       WSUM_W    = 9;
  localparam logic [WSUM_W-1:0] WDAY_BIAS = WSUM_W'(202);
  localparam logic [3:0]        WEEK_DAYS = 4'd7;
  localparam logic [MONTH_W:0]  MONTH_WRAP = (MONTH_W + 1)'(12);
  localparam logic [CENT_W-1:0] YREM_TOP  = CENT_W'(CENTURY - 1);

  localparam logic [YEAR_W-1:0]  RST_YEAR  = YEAR_W'(2000);
  localparam logic [MONTH_W-1:0] RST_MONTH = MONTH_JAN;
  localparam logic [DAY_W-1:0]   RST_DAY   = DAY_W'(1);

  // (26 * (m + 1)) / 10 for the shifted month 3..14
  function automatic logic [5:0] month_term(input logic [MONTH_W:0] mm);
    logic [5:0] t;
    unique case (mm)
      5'd3:    t = 6'd10;
      5'd4:    t = 6'd13;
      5'd5:    t = 6'd15;
      5'd6:    t = 6'd18;
      5'd7:    t = 6'd20;
      5'd8:    t = 6'd23;
      5'd9:    t = 6'd26;
      5'd10:   t = 6'd28;
      5'd11:   t = 6'd31;
      5'd12:   t = 6'd33;
      5'd13:   t = 6'd36;
      5'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [WDAY_W-1:0] weekday_of(input logic [MONTH_W-1:0] month,
                                                   input logic [DAY_W-1:0]   day,
                                                   input logic [CENT_W-1:0]  cent,
                                                   input logic [CENT_W-1:0]  yrem);
    logic [CENT_W-1:0] yy;
    logic [CENT_W-1:0] cc;
    logic [MONTH_W:0]  mm;
    logic [WSUM_W-1:0] w;
    logic [4:0]        s1;
    logic [3:0]        s2;
    // January and February count as months 13 and 14 of the prior year
    if (month <= MONTH_FEB) begin
      mm = (MONTH_W + 1)'(month) + MONTH_WRAP;
      if (yrem == '0) begin
        yy = YREM_TOP;
        cc = cent - 1'b1;
      end else begin
        yy = yrem - 1'b1;
        cc = cent;
      end
    end else begin
      mm = (MONTH_W + 1)'(month);
      yy = yrem;
      cc = cent;
    end
    // bias keeps the sum positive; the result stays below 512
    w = WSUM_W'(yy) + WSUM_W'(yy >> 2) + WSUM_W'(cc >> 2) + WSUM_W'(month_term(mm))
        + WSUM_W'(day) + WDAY_BIAS - WSUM_W'({cc, 1'b0});
    // 8 = 1 mod 7: fold octal digits, then one compare and subtract
    s1 = 5'(w[8:6]) + 5'(w[5:3]) + 5'(w[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    return (s2 >= WEEK_DAYS) ? WDAY_W'(s2 - WEEK_DAYS) : s2[WDAY_W-1:0];
  endfunction

  logic [YEAR_W-1:0]  cur_year_q, cur_year_d;
  logic [MONTH_W-1:0] cur_month_q, cur_month_d;
  logic [DAY_W-1:0]   cur_day_q, cur_day_d;

  logic               out_valid_q, out_valid_d;
  logic [YEAR_W-1:0]  out_year_q, out_year_d;
  logic [MONTH_W-1:0] out_month_q, out_month_d;
  logic [DAY_W-1:0]   out_day_q, out_day_d;
  logic [WDAY_W-1:0]  out_wday_q, out_wday_d;
  logic               out_err_q, out_err_d;

  gda_ctrl_t          walk_ctrl;
  gda_stat_t          walk_stat;
  gda_res_t           walk_res;
  logic               out_free;
  logic [MONTH_W-1:0] cfg_month;
  logic [YEAR_W-1:0]  sel_year;
  logic [MONTH_W-1:0] sel_month;
  logic [DAY_W-1:0]   sel_day;

  assign in_stall_o      = walk_stat.busy;
  assign out_free        = !out_valid_q || !out_stall_i;
  assign walk_ctrl.start = in_valid_i && !in_stall_o;
  assign walk_ctrl.take  = walk_stat.done && out_free;

  gda_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (walk_ctrl),
    .offset_i (day_offset_i),
    .year_i   (cur_year_q),
    .month_i  (cur_month_q),
    .day_i    (cur_day_q),
    .stat_o   (walk_stat),
    .res_o    (walk_res)
  );

  assign cfg_month = cfg_wdata_i[MONTH_W-1:0];

  always_comb begin
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_YEAR: begin
          if (cfg_wdata_i < YEAR_MIN) begin
            cur_year_d = YEAR_MIN;
          end else if (cfg_wdata_i > YEAR_MAX) begin
            cur_year_d = YEAR_MAX;
          end else begin
            cur_year_d = cfg_wdata_i;
          end
        end
        CFG_START_MONTH: begin
          if (cfg_month < MONTH_JAN) begin
            cur_month_d = MONTH_JAN;
          end else if (cfg_month > MONTH_DEC) begin
            cur_month_d = MONTH_DEC;
          end else begin
            cur_month_d = cfg_month;
          end
        end
        CFG_START_DAY: begin
          cur_day_d = cfg_wdata_i[DAY_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (walk_ctrl.take && !walk_res.err) begin
      cur_year_d  = walk_res.year;
      cur_month_d = walk_res.month;
      cur_day_d   = walk_res.day;
    end
  end

  // hold the current date on a range error
  assign sel_year  = walk_res.err ? cur_year_q  : walk_res.year;
  assign sel_month = walk_res.err ? cur_month_q : walk_res.month;
  assign sel_day   = walk_res.err ? cur_day_q   : walk_res.day;

  always_comb begin
    out_valid_d = out_valid_q;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    out_wday_d  = out_wday_q;
    out_err_d   = out_err_q;
    if (walk_ctrl.take) begin
      out_valid_d = 1'b1;
      out_year_d  = sel_year;
      out_month_d = sel_month;
      out_day_d   = sel_day;
      out_wday_d  = weekday_of(sel_month, sel_day, walk_res.cent, walk_res.yrem);
      out_err_d   = walk_res.err;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= RST_YEAR;
      cur_month_q <= RST_MONTH;
      cur_day_q   <= RST_DAY;
      out_valid_q <= 1'b0;
    end else begin
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_wday_q  <= out_wday_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_year_o    = out_year_q;
  assign out_month_o   = out_month_q;
  assign out_day_o     = out_day_q;
  assign weekday_o     = out_wday_q;
  assign range_error_o = out_err_q;

  `GDA_ASSERT(a_cur_range, cur_year_q >= YEAR_MIN && cur_year_q <= YEAR_MAX && cur_month_q >= MONTH_JAN && cur_month_q <= MONTH_DEC, "current date out of range")
  `GDA_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "request accepted but walk not started")
  `GDA_ASSERT_IMPL(a_out_is_cur, out_valid_q, out_year_q == cur_year_q && out_month_q == cur_month_q && out_day_q == cur_day_q, "pending result differs from current date")

endmodule
